// ===== rtl/ard_pkg.sv =====
`timescale 1ns / 1ps
package ard_pkg;

  typedef enum logic [2:0] {
    FN_ADD   = 3'd0,
    FN_REM   = 3'd1,
    FN_READ  = 3'd2,
    FN_WRITE = 3'd3,
    FN_CLEAR = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_REGION = 3'd1,
    ST_DENIED    = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAIT,
    S_TBL,
    S_HIT,
    S_PICK,
    S_FAST,
    S_EMIT
  } state_t;

  localparam logic [3:0] MASK_RD     = 4'h1;
  localparam logic [3:0] MASK_RD_SUP = 4'h5;
  localparam logic [3:0] MASK_WR     = 4'h2;
  localparam logic [3:0] MASK_WR_SUP = 4'hA;
  localparam logic [7:0] BYTE_MASK   = 8'hff;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] len;
    logic [3:0]  flags;
    logic [7:0]  target;
  } entry_t;

  typedef struct packed {
    logic ins;  // take the entry of the newer neighbor
    logic rem;  // take the entry of the older neighbor
  } cell_ctl_t;

endpackage

// ===== rtl/ard_cell.sv =====
`timescale 1ns / 1ps
module ard_cell (
  input  logic              clk,
  input  ard_pkg::cell_ctl_t ctl,
  input  ard_pkg::entry_t   prev_ent,
  input  ard_pkg::entry_t   next_ent,
  input  logic [31:0]       look_addr,
  output ard_pkg::entry_t   ent,
  output logic              match,
  output logic              base_eq
);
  import ard_pkg::*;

  entry_t ent_r;
  logic   match_r;
  logic   eq_r;
  logic [31:0] diff;

  assign diff = look_addr - ent_r.base;

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      ent_r <= prev_ent;
    end else if (ctl.rem) begin
      ent_r <= next_ent;
    end
    match_r <= (look_addr >= ent_r.base) && (diff < ent_r.len);
    eq_r    <= (ent_r.base == look_addr);
  end

  assign ent     = ent_r;
  assign match   = match_r;
  assign base_eq = eq_r;
endmodule

// ===== rtl/address_region_decoder_top.sv =====
// Table ops (add, remove, clear) pass S_WAIT, then S_TBL registers the status result.
// Accesses look up in S_HIT, S_PICK on a last-hit miss, and S_FAST; the fast path
// gives one result per cycle unless stalled; byte by byte, each byte redoes the lookup.
// One request is worked on at a time; the output register lets the next one start.
// Reset (rst_n, synchronous, active low) empties the table and the last-hit region.
`timescale 1ns / 1ps
module address_region_decoder_top #(
  parameter int MAX_REGIONS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // address[31:0], length[63:32], region_flags[67:64], target[75:68],
  // access_size[78:76], write_value[110:79], supervisor[111]
  input  logic [111:0] in_tdata,
  // func[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // region_target[7:0], byte_offset[39:8], byte_data[47:40], status[50:48]
  output logic [55:0]  out_tdata,
  // kind[1:0]
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);
  import ard_pkg::*;

  localparam int CW = $clog2(MAX_REGIONS + 1);

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [2:0]  func_r, func_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [31:0] len_r, len_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic [7:0]  tgt_r, tgt_nxt;
  logic [2:0]  n_r, n_nxt;
  logic [31:0] wv_r, wv_nxt;
  logic        sup_r, sup_nxt;
  logic [31:0] la_r, la_nxt;
  logic [2:0]  i_r, i_nxt;
  logic        phase_r, phase_nxt;
  logic        fast_r, fast_nxt;
  logic        found_r, found_nxt;
  logic        hv_r, hv_nxt;
  entry_t      hit_r, hit_nxt;
  logic        ov_r, ov_nxt;
  logic [55:0] od_r, od_nxt;
  logic [1:0]  ou_r, ou_nxt;
  logic        ol_r, ol_nxt;

  entry_t    ents [MAX_REGIONS];
  cell_ctl_t ctls [MAX_REGIONS];
  logic [MAX_REGIONS-1:0] match_v, eq_v, active, m, first, eqm, eqfirst, shmask;
  entry_t sel;

  genvar g;
  generate
    for (g = 0; g < MAX_REGIONS; g++) begin : g_cell
      entry_t pe, ne;
      if (g == 0) begin : g_head
        assign pe = '{base: addr_r, len: len_r, flags: flags_r, target: tgt_r};
      end else begin : g_mid
        assign pe = ents[g-1];
      end
      if (g == MAX_REGIONS - 1) begin : g_tail
        assign ne = ents[g];
      end else begin : g_body
        assign ne = ents[g+1];
      end
      assign active[g] = (CW'(g) < count_r);
      ard_cell u_cell (
        .clk      (clk),
        .ctl      (ctls[g]),
        .prev_ent (pe),
        .next_ent (ne),
        .look_addr(la_r),
        .ent      (ents[g]),
        .match    (match_v[g]),
        .base_eq  (eq_v[g])
      );
    end
  endgenerate

  assign m       = match_v & active;
  assign first   = m & (~m + 1'b1);
  assign eqm     = eq_v & active;
  // Cells from the newest matching base onward take their older neighbor.
  assign eqfirst = eqm & (~eqm + 1'b1);
  assign shmask  = ~(eqfirst - 1'b1);

  always_comb begin
    sel = '0;
    for (int j = 0; j < MAX_REGIONS; j++) begin
      sel = sel | (ents[j] & {$bits(entry_t){first[j]}});
    end
  end

  logic        wr, in_acc, out_free, hit_in, perm, fast_ok, is_last;
  logic [2:0]  idx, idx_n, shamt, in_n;
  logic [31:0] byte_a, hoff, hdiff;
  logic [7:0]  bdata;
  logic [3:0]  mask;
  logic [32:0] end33, offn;

  assign wr       = (func_r == FN_WRITE);
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !ov_r || out_tready;
  assign mask     = wr ? (sup_r ? MASK_WR_SUP : MASK_WR) : (sup_r ? MASK_RD_SUP : MASK_RD);
  assign perm     = |(hit_r.flags & mask);
  assign hdiff    = la_r - hit_r.base;
  assign hit_in   = hv_r && (la_r >= hit_r.base) && (hdiff < hit_r.len);
  assign idx      = wr ? (n_r - 3'd1 - i_r) : i_r;
  assign idx_n    = wr ? (n_r - 3'd2 - i_r) : (i_r + 3'd1);
  assign byte_a   = addr_r + 32'(idx);
  assign hoff     = byte_a - hit_r.base;
  assign shamt    = n_r - 3'd1 - idx;
  assign bdata    = 8'(wv_r >> {shamt, 3'b000}) & BYTE_MASK;
  assign end33    = {1'b0, addr_r} + 33'(n_r);
  assign offn     = {1'b0, addr_r - hit_r.base} + 33'(n_r);
  assign fast_ok  = found_r && perm && (end33 <= 33'h1_0000_0000) &&
                    (offn <= {1'b0, hit_r.len});
  assign is_last  = (i_r == n_r - 3'd1);
  assign in_n     = (in_tdata[78:76] == 3'd0) ? 3'd1 :
                    (in_tdata[78:76] > 3'd4) ? 3'd4 : in_tdata[78:76];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            FN_ADD, FN_REM, FN_CLEAR: state_nxt = S_WAIT;
            FN_READ, FN_WRITE:        state_nxt = S_HIT;
            default:                  state_nxt = S_IDLE;
          endcase
        end
      end
      S_WAIT: state_nxt = S_TBL;
      S_TBL:  if (out_free) state_nxt = S_IDLE;
      S_HIT:  state_nxt = hit_in ? (phase_r ? S_EMIT : S_FAST) : S_PICK;
      S_PICK: state_nxt = phase_r ? S_EMIT : S_FAST;
      S_FAST: state_nxt = fast_ok ? S_EMIT : S_HIT;
      S_EMIT: begin
        if (out_free) begin
          state_nxt = is_last ? S_IDLE : (fast_r ? S_EMIT : S_HIT);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    logic add_go, rem_go;
    count_nxt = count_r; func_nxt = func_r; addr_nxt = addr_r; len_nxt = len_r;
    flags_nxt = flags_r; tgt_nxt = tgt_r; n_nxt = n_r; wv_nxt = wv_r; sup_nxt = sup_r;
    la_nxt = la_r; i_nxt = i_r; phase_nxt = phase_r; fast_nxt = fast_r;
    found_nxt = found_r; hv_nxt = hv_r; hit_nxt = hit_r;
    ov_nxt = ov_r && !out_tready; od_nxt = od_r; ou_nxt = ou_r; ol_nxt = ol_r;
    add_go = 1'b0;
    rem_go = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          func_nxt  = in_tuser;
          addr_nxt  = in_tdata[31:0];
          len_nxt   = in_tdata[63:32];
          flags_nxt = in_tdata[67:64];
          tgt_nxt   = in_tdata[75:68];
          n_nxt     = in_n;
          wv_nxt    = in_tdata[110:79];
          sup_nxt   = in_tdata[111];
          la_nxt    = in_tdata[31:0];
          phase_nxt = 1'b0;
          fast_nxt  = 1'b0;
          i_nxt     = 3'd0;
        end
      end
      S_TBL: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          ou_nxt = KIND_STATUS;
          ol_nxt = 1'b1;
          od_nxt = '0;
          case (func_r)
            FN_ADD: begin
              if (count_r < CW'(MAX_REGIONS)) begin
                add_go    = 1'b1;
                count_nxt = count_r + 1'b1;
                od_nxt[50:48] = ST_OK;
              end else begin
                od_nxt[50:48] = ST_FULL;
              end
            end
            FN_REM: begin
              hv_nxt = 1'b0;
              if (|eqm) begin
                rem_go    = 1'b1;
                count_nxt = count_r - 1'b1;
                od_nxt[50:48] = ST_OK;
              end else begin
                od_nxt[50:48] = ST_NOT_FOUND;
              end
            end
            default: begin
              count_nxt = '0;
              hv_nxt    = 1'b0;
              od_nxt[50:48] = ST_OK;
            end
          endcase
        end
      end
      S_HIT: begin
        if (hit_in) found_nxt = 1'b1;
      end
      S_PICK: begin
        if (|m) begin
          found_nxt = 1'b1;
          hv_nxt    = 1'b1;
          hit_nxt   = sel;
        end else begin
          found_nxt = 1'b0;
        end
      end
      S_FAST: begin
        phase_nxt = 1'b1;
        fast_nxt  = fast_ok;
        i_nxt     = 3'd0;
        la_nxt    = addr_r + 32'(wr ? n_r - 3'd1 : 3'd0);
      end
      S_EMIT: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          ol_nxt = is_last;
          od_nxt = '0;
          if (fast_r || (found_r && perm)) begin
            ou_nxt = wr ? KIND_WRITE : KIND_READ;
            od_nxt[7:0]   = hit_r.target;
            od_nxt[39:8]  = hoff;
            od_nxt[47:40] = wr ? bdata : 8'd0;
            od_nxt[50:48] = ST_OK;
          end else if (found_r) begin
            ou_nxt = KIND_STATUS;
            od_nxt[7:0]   = hit_r.target;
            od_nxt[39:8]  = hoff;
            od_nxt[50:48] = ST_DENIED;
          end else begin
            ou_nxt = KIND_STATUS;
            od_nxt[50:48] = ST_NO_REGION;
          end
          if (!is_last) begin
            i_nxt  = i_r + 3'd1;
            la_nxt = addr_r + 32'(idx_n);
          end
        end
      end
      default: begin
      end
    endcase
    for (int j = 0; j < MAX_REGIONS; j++) begin
      ctls[j].ins = add_go;
      ctls[j].rem = rem_go && shmask[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      hv_r    <= 1'b0;
      hit_r   <= '0;
      ov_r    <= 1'b0;
      fast_r  <= 1'b0;
      found_r <= 1'b0;
      phase_r <= 1'b0;
      i_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      hv_r    <= hv_nxt;
      hit_r   <= hit_nxt;
      ov_r    <= ov_nxt;
      fast_r  <= fast_nxt;
      found_r <= found_nxt;
      phase_r <= phase_nxt;
      i_r     <= i_nxt;
    end
    func_r <= func_nxt; addr_r <= addr_nxt; len_r <= len_nxt; flags_r <= flags_nxt;
    tgt_r <= tgt_nxt; n_r <= n_nxt; wv_r <= wv_nxt; sup_r <= sup_nxt; la_r <= la_nxt;
    od_r <= od_nxt; ou_r <= ou_nxt; ol_r <= ol_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_REGIONS)) else $error("region count above table size");

  a_fast_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && fast_r) |-> (found_r && hv_r))
    else $error("fast path without a loaded hit region");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r) || count_r == $past(count_r) + 1'b1 ||
                      count_r == $past(count_r) - 1'b1 || count_r == '0))
    else $error("region count jumped");
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import ard_pkg::*;

  localparam int TABLE_DEPTH = 16;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  target;
    logic [31:0] offset;
    logic [7:0]  data;
    logic [2:0]  status;
    logic        last;
  } byte_result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic [2:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [55:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  address_region_decoder_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // Shadow of the region table and the last-hit register.
  logic [31:0] map_base [TABLE_DEPTH];
  logic [31:0] map_len [TABLE_DEPTH];
  logic [3:0]  map_flags [TABLE_DEPTH];
  logic [7:0]  map_target [TABLE_DEPTH];
  int          map_count;
  logic        hit_ok;
  logic [31:0] hit_b;
  logic [31:0] hit_l;
  logic [3:0]  hit_f;
  logic [7:0]  hit_t;

  byte_result_t pending_results[$];
  int           errors;
  bit           idle_enable;
  bit           hold_off;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("address_region_decoder_top regression: fail");
    $finish;
  end

  function automatic bit in_region(logic [31:0] b, logic [31:0] l, logic [31:0] a);
    logic [31:0] d;
    d = a - b;
    return (a >= b) && (d < l);
  endfunction

  function automatic bit find_region(logic [31:0] a);
    if (hit_ok && in_region(hit_b, hit_l, a)) return 1'b1;
    for (int i = 0; i < map_count; i++) begin
      if (in_region(map_base[i], map_len[i], a)) begin
        hit_ok = 1'b1;
        hit_b = map_base[i];
        hit_l = map_len[i];
        hit_f = map_flags[i];
        hit_t = map_target[i];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void push_result(logic [1:0] k, logic [7:0] t, logic [31:0] o,
                                      logic [7:0] d, logic [2:0] s, logic l);
    byte_result_t r;
    r.kind = k;
    r.target = t;
    r.offset = o;
    r.data = d;
    r.status = s;
    r.last = l;
    pending_results.push_back(r);
  endfunction

  function automatic void decode_request(logic [2:0] fn, logic [31:0] addr,
                                         logic [31:0] len, logic [3:0] flg,
                                         logic [7:0] tgt, logic [2:0] size,
                                         logic [31:0] val, logic sup);
    logic [2:0]  st;
    logic [3:0]  mask;
    logic [63:0] off;
    logic [31:0] a;
    logic [7:0]  d;
    int          n;
    int          idx;
    bit          wr;
    bit          fast;
    case (fn)
      FN_ADD: begin
        st = ST_FULL;
        if (map_count < TABLE_DEPTH) begin
          for (int i = map_count; i > 0; i--) begin
            map_base[i] = map_base[i-1];
            map_len[i] = map_len[i-1];
            map_flags[i] = map_flags[i-1];
            map_target[i] = map_target[i-1];
          end
          map_base[0] = addr;
          map_len[0] = len;
          map_flags[0] = flg;
          map_target[0] = tgt;
          map_count++;
          st = ST_OK;
        end
        push_result(KIND_STATUS, 0, 0, 0, st, 1'b1);
      end
      FN_REM: begin
        st = ST_NOT_FOUND;
        hit_ok = 1'b0;
        for (int i = 0; i < map_count; i++) begin
          if (map_base[i] == addr) begin
            for (int j = i; j + 1 < map_count; j++) begin
              map_base[j] = map_base[j+1];
              map_len[j] = map_len[j+1];
              map_flags[j] = map_flags[j+1];
              map_target[j] = map_target[j+1];
            end
            map_count--;
            st = ST_OK;
            break;
          end
        end
        push_result(KIND_STATUS, 0, 0, 0, st, 1'b1);
      end
      FN_CLEAR: begin
        map_count = 0;
        hit_ok = 1'b0;
        push_result(KIND_STATUS, 0, 0, 0, ST_OK, 1'b1);
      end
      FN_READ, FN_WRITE: begin
        wr = (fn == FN_WRITE);
        mask = wr ? (sup ? MASK_WR_SUP : MASK_WR) : (sup ? MASK_RD_SUP : MASK_RD);
        n = (size == 0) ? 1 : (size > 4) ? 4 : int'(size);
        fast = 1'b0;
        if (find_region(addr)) begin
          off = {32'd0, addr - hit_b};
          if (off + n <= {32'd0, hit_l} && {32'd0, addr} + n <= 64'h1_0000_0000 &&
              (hit_f & mask) != 0)
            fast = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
          idx = wr ? (n - 1 - i) : i;
          a = addr + idx;
          d = wr ? 8'(val >> (8 * (n - 1 - idx))) : 8'd0;
          if (fast)
            push_result(wr ? KIND_WRITE : KIND_READ, hit_t, a - hit_b, d, ST_OK, i == n-1);
          else if (!find_region(a))
            push_result(KIND_STATUS, 0, 0, 0, ST_NO_REGION, i == n-1);
          else if ((hit_f & mask) == 0)
            push_result(KIND_STATUS, hit_t, a - hit_b, 0, ST_DENIED, i == n-1);
          else
            push_result(wr ? KIND_WRITE : KIND_READ, hit_t, a - hit_b, d, ST_OK, i == n-1);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Valid stays high after an accepted request when the next one follows at once.
  task automatic send_request(logic [2:0] fn, logic [31:0] addr, logic [31:0] len,
                              logic [3:0] flg, logic [7:0] tgt, logic [2:0] size,
                              logic [31:0] val, logic sup);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= fn;
    in_tdata <= {sup, val, size, tgt, flg, len, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_request(fn, addr, len, flg, tgt, size, val, sup);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int burst;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 7);
        out_tready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Checker: compares every accepted result with the oldest expectation.
  initial begin
    byte_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result offset", out_tdata[39:8], 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (out_tuser != want.kind)
            report_mismatch("kind", 32'(out_tuser), 32'(want.kind));
          if (out_tdata[7:0] != want.target)
            report_mismatch("target", 32'(out_tdata[7:0]), 32'(want.target));
          if (out_tdata[39:8] != want.offset)
            report_mismatch("offset", out_tdata[39:8], want.offset);
          if (out_tdata[47:40] != want.data)
            report_mismatch("data", 32'(out_tdata[47:40]), 32'(want.data));
          if (out_tdata[50:48] != want.status)
            report_mismatch("status", 32'(out_tdata[50:48]), 32'(want.status));
          if (out_tlast != want.last)
            report_mismatch("last", 32'(out_tlast), 32'(want.last));
        end
      end
    end
  end

  task automatic test_directed;
    send_request(FN_READ, 32'h100, 0, 0, 0, 1, 0, 0);
    send_request(FN_REM, 32'h100, 0, 0, 0, 1, 0, 0);
    send_request(FN_ADD, 32'h1000, 32'h100, 4'h3, 8'h11, 1, 0, 0);
    send_request(FN_ADD, 32'h2000, 32'h10, 4'hC, 8'h22, 1, 0, 0);
    send_request(FN_ADD, 32'hFFFF_FFF0, 32'h10, 4'hF, 8'hFF, 1, 0, 0);
    send_request(FN_READ, 32'h1000, 0, 0, 0, 4, 0, 0);
    send_request(FN_WRITE, 32'h1004, 0, 0, 0, 4, 32'hDEADBEEF, 0);
    send_request(FN_WRITE, 32'h10FE, 0, 0, 0, 4, 32'h01020304, 1);
    send_request(FN_READ, 32'h2000, 0, 0, 0, 2, 0, 0);
    send_request(FN_READ, 32'h2000, 0, 0, 0, 2, 0, 1);
    send_request(FN_WRITE, 32'h200E, 0, 0, 0, 4, 32'hFFFFFFFF, 1);
    send_request(FN_READ, 32'hFFFF_FFFE, 0, 0, 0, 4, 0, 0);
    send_request(FN_READ, 32'h1000, 0, 0, 0, 0, 0, 0);
    send_request(FN_READ, 32'h1000, 0, 0, 0, 7, 0, 0);
    send_request(FN_WRITE, 32'h1000, 0, 0, 0, 3, 32'h00ABCDEF, 0);
    send_request(3'd5, 32'h1000, 0, 0, 0, 1, 0, 0);
    send_request(3'd7, 32'h1000, 0, 0, 0, 1, 0, 0);
    send_request(FN_REM, 32'h2000, 0, 0, 0, 1, 0, 0);
    send_request(FN_REM, 32'h2000, 0, 0, 0, 1, 0, 0);
    for (int i = 0; i < 15; i++)
      send_request(FN_ADD, 32'h4000 + i * 16, 16, i[3:0], i[7:0], 1, 0, 0);
    send_request(FN_ADD, 32'h9000, 16, 4'hF, 8'h99, 1, 0, 0);
    send_request(FN_CLEAR, 0, 0, 0, 0, 1, 0, 0);
  endtask

  task automatic random_request;
    logic [2:0]  fn;
    logic [31:0] addr;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) fn = FN_ADD;
    else if (pick < 22) fn = FN_REM;
    else if (pick < 24) fn = FN_CLEAR;
    else if (pick < 26) fn = 3'($urandom_range(5, 7));
    else fn = (pick < 63) ? FN_READ : FN_WRITE;
    if ($urandom_range(0, 9) == 0) addr = $urandom;
    else if ($urandom_range(0, 9) == 0) addr = 32'hFFFF_FFF0 + $urandom_range(0, 15);
    else addr = {20'h0, 4'($urandom_range(0, 3)), 8'($urandom_range(0, 255))};
    if (fn == FN_REM && map_count > 0 && $urandom_range(0, 3) != 0)
      addr = map_base[$urandom_range(0, map_count - 1)];
    send_request(fn, addr,
                 ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 600),
                 4'($urandom), 8'($urandom), 3'($urandom), $urandom, 1'($urandom));
  endtask

  task automatic test_random;
    for (int i = 0; i < 300; i++) random_request();
  endtask

  task automatic test_backpressure;
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++)
      send_request(FN_READ, 32'($urandom_range(0, 1023)), 0, 0, 0, 4, $urandom, 1);
  endtask

  task automatic test_quiet_tail;
    idle_enable = 1'b0;
    for (int i = 0; i < 30; i++) random_request();
  endtask

  initial begin
    errors = 0;
    idle_enable = 1'b1;
    hold_off = 1'b0;
    map_count = 0;
    hit_ok = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    test_quiet_tail();
    in_tvalid <= 1'b0;
    drain();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("address_region_decoder_top regression: pass");
    end else begin
      $display("address_region_decoder_top regression: fail");
    end
    $finish;
  end

endmodule
